@@ sv/b64d_pkg.sv @@
package b64d_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [7:0] CHAR_PAD = 8'h3d;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    typedef struct packed {
        logic [7:0] byte2;
        logic [7:0] byte1;
        logic [7:0] byte0;
        logic [1:0] nbytes;
        logic       is_end;
    } job_t;

    typedef struct packed {
        logic push;
        logic full;
    } qwr_ctl_t;

    typedef struct packed {
        logic pop;
        logic nonempty;
    } qrd_ctl_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            s.value = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7a)
        begin
            s.value = 6'(c - 8'd71);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            s.value = 6'(c + 8'd4);
        end
        else if (c == 8'h2b)
        begin
            s.value = 6'd62;
        end
        else if (c == 8'h2f)
        begin
            s.value = 6'd63;
        end
        else
        begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

@@ sv/b64d_front.sv @@
module b64d_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         in_char,
    input  logic               in_last,
    output logic               in_ready,
    input  logic               q_full,
    output logic               q_push,
    output b64d_pkg::job_t     q_job
);

    logic [5:0] buf0_reg, buf0_next;
    logic [5:0] buf1_reg, buf1_next;
    logic [5:0] buf2_reg, buf2_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pad_reg, pad_next;

    b64d_pkg::sextet_t sx;
    logic       fire;
    logic       is_pad;
    logic       take;
    logic       full_grp;
    logic [5:0] u0, u1, u2;
    logic [1:0] ucnt;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;
    assign sx       = b64d_pkg::sextet_of(in_char);
    assign is_pad   = (in_char == b64d_pkg::CHAR_PAD);
    assign take     = !pad_reg && !is_pad && sx.valid;
    assign full_grp = take && (cnt_reg == 2'd3);

    always_comb
    begin
        u0   = buf0_reg;
        u1   = buf1_reg;
        u2   = buf2_reg;
        ucnt = cnt_reg;
        if (take && !full_grp)
        begin
            unique case (cnt_reg)
                2'd0:    u0 = sx.value;
                2'd1:    u1 = sx.value;
                default: u2 = sx.value;
            endcase
            ucnt = cnt_reg + 2'd1;
        end
        else if (full_grp)
        begin
            u0   = 6'd0;
            u1   = 6'd0;
            u2   = 6'd0;
            ucnt = 2'd0;
        end
    end

    always_comb
    begin
        q_job.is_end = in_last;
        if (full_grp)
        begin
            q_job.byte0  = {buf0_reg, buf1_reg[5:4]};
            q_job.byte1  = {buf1_reg[3:0], buf2_reg[5:2]};
            q_job.byte2  = {buf2_reg[1:0], sx.value};
            q_job.nbytes = 2'd3;
        end
        else
        begin
            q_job.byte0 = {u0, u1[5:4]};
            q_job.byte1 = {u1[3:0], u2[5:2]};
            q_job.byte2 = 8'd0;
            unique case (ucnt)
                2'd3:    q_job.nbytes = 2'd2;
                2'd2:    q_job.nbytes = 2'd1;
                default: q_job.nbytes = 2'd0;
            endcase
        end
    end

    assign q_push = fire && (full_grp || in_last);

    always_comb
    begin
        buf0_next = buf0_reg;
        buf1_next = buf1_reg;
        buf2_next = buf2_reg;
        cnt_next  = cnt_reg;
        pad_next  = pad_reg;
        if (fire)
        begin
            if (in_last)
            begin
                buf0_next = 6'd0;
                buf1_next = 6'd0;
                buf2_next = 6'd0;
                cnt_next  = 2'd0;
                pad_next  = 1'b0;
            end
            else
            begin
                buf0_next = u0;
                buf1_next = u1;
                buf2_next = u2;
                cnt_next  = ucnt;
                pad_next  = pad_reg || is_pad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf0_reg <= 6'd0;
            buf1_reg <= 6'd0;
            buf2_reg <= 6'd0;
            cnt_reg  <= 2'd0;
            pad_reg  <= 1'b0;
        end
        else
        begin
            buf0_reg <= buf0_next;
            buf1_reg <= buf1_next;
            buf2_reg <= buf2_next;
            cnt_reg  <= cnt_next;
            pad_reg  <= pad_next;
        end
    end

endmodule

@@ sv/b64d_queue.sv @@
module b64d_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  b64d_pkg::job_t       wr_job,
    output b64d_pkg::qwr_ctl_t   wr_ctl,
    input  logic                 pop,
    output b64d_pkg::qrd_ctl_t   rd_ctl,
    output b64d_pkg::job_t       rd_job
);

    b64d_pkg::job_t mem_reg [b64d_pkg::QDEPTH];

    logic [b64d_pkg::QPTR_W-1:0] wp_reg, wp_next;
    logic [b64d_pkg::QPTR_W-1:0] rp_reg, rp_next;
    logic [b64d_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                        do_push;
    logic                        do_pop;

    assign wr_ctl.push     = push;
    assign wr_ctl.full     = (cnt_reg == b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH));
    assign rd_ctl.pop      = pop;
    assign rd_ctl.nonempty = (cnt_reg != '0);
    assign rd_job          = mem_reg[rp_reg];

    assign do_push = push && !wr_ctl.full;
    assign do_pop  = pop && rd_ctl.nonempty;

    always_comb
    begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wr_job;
        end
    end

endmodule

@@ sv/b64d_back.sv @@
module b64d_back #(
    parameter int LEN_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          limit,
    input  b64d_pkg::qrd_ctl_t   q_ctl,
    input  b64d_pkg::job_t       q_job,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_end,
    output logic                 out_status,
    output logic [15:0]          out_len
);

    localparam int W = (LEN_BITS > 16) ? LEN_BITS : 16;

    logic [1:0]          pos_reg, pos_next;
    logic [LEN_BITS-1:0] count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic                ov_reg, ov_next;
    logic [7:0]          byte_reg, byte_next;
    logic                end_reg, end_next;
    logic                status_reg, status_next;
    logic [15:0]         len_reg, len_next;

    logic          can_load;
    logic          fire;
    logic          end_act;
    logic          last_act;
    logic          over;
    logic [W-1:0]  lim_w;
    logic [W-1:0]  mask_w;
    logic [W-1:0]  lim_eff;
    logic [7:0]    sel_byte;

    assign mask_w  = W'({LEN_BITS{1'b1}});
    assign lim_w   = W'(limit);
    assign lim_eff = (lim_w > mask_w) ? mask_w : lim_w;
    assign over    = ovf_reg || (W'(count_reg) >= lim_eff);

    assign can_load = !ov_reg || out_ready;
    assign fire     = q_ctl.nonempty && can_load;
    assign end_act  = (pos_reg == q_job.nbytes);
    assign last_act = end_act || (!q_job.is_end && (pos_reg == q_job.nbytes - 2'd1));
    assign q_pop    = fire && last_act;

    always_comb
    begin
        unique case (pos_reg)
            2'd0:    sel_byte = q_job.byte0;
            2'd1:    sel_byte = q_job.byte1;
            default: sel_byte = q_job.byte2;
        endcase
    end

    always_comb
    begin
        pos_next    = pos_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        ov_next     = out_ready ? 1'b0 : ov_reg;
        byte_next   = byte_reg;
        end_next    = end_reg;
        status_next = status_reg;
        len_next    = len_reg;
        if (fire)
        begin
            pos_next = last_act ? 2'd0 : pos_reg + 2'd1;
            if (end_act)
            begin
                ov_next     = 1'b1;
                byte_next   = 8'd0;
                end_next    = 1'b1;
                status_next = ovf_reg;
                len_next    = ovf_reg ? 16'd0 : 16'(count_reg);
                count_next  = '0;
                ovf_next    = 1'b0;
            end
            else if (over)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                ov_next     = 1'b1;
                byte_next   = sel_byte;
                end_next    = 1'b0;
                status_next = 1'b0;
                len_next    = 16'd0;
                count_next  = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 2'd0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        end_reg    <= end_next;
        status_reg <= status_next;
        len_reg    <= len_next;
    end

    assign out_valid  = ov_reg;
    assign out_byte   = byte_reg;
    assign out_end    = end_reg;
    assign out_status = status_reg;
    assign out_len    = len_reg;

endmodule

@@ sv/base64_stream_decoder_top.sv @@
// Streaming Base64 decoder, standard alphabet.
// s_* : one character per request, s_tlast on the final character of a text.
//       Non-alphabet characters are skipped; the first '=' ends decoding
//       until s_tlast. An empty text is one s_tlast request with a skipped char.
// m_* : one result per request. Byte results have m_tlast = 0; the closing
//       result of each text has m_tlast = 1 with status and decoded length.
// cfg_* : write of output_limit, only while the block is idle; always ready.
// A result passes through the job queue and then the back end's result register.
// Throughput: one character per cycle while results keep up; the back end
//   issues one result per cycle while m_tready is high, so a full group plus
//   end makes four results, and suppressed bytes after an overflow each take
//   a step of the back end with no result. A four-entry job queue between the
//   classifier and the emitter absorbs the difference.
// Reset: text state clears, output_limit returns to 65535, no result pending.
// Stall: a held m_tready keeps the result register; the queue fills and then
//   s_tready drops until it drains.
module base64_stream_decoder_top #(
    parameter int LEN_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [8] status, [24:9] total_len, rest 0
    output logic        m_tlast,   // is_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0] limit_reg, limit_next;

    b64d_pkg::job_t     push_job;
    b64d_pkg::job_t     head_job;
    b64d_pkg::qwr_ctl_t wr_ctl;
    b64d_pkg::qrd_ctl_t rd_ctl;
    logic               push;
    logic               pop;
    logic [7:0]         out_byte;
    logic               out_status;
    logic [15:0]        out_len;

    assign cfg_ready  = 1'b1;
    assign limit_next = (cfg_valid && cfg_ready) ? cfg_data : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 16'hffff;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_char  (s_tdata),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .q_full   (wr_ctl.full),
        .q_push   (push),
        .q_job    (push_job)
    );

    b64d_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (push_job),
        .wr_ctl (wr_ctl),
        .pop    (pop),
        .rd_ctl (rd_ctl),
        .rd_job (head_job)
    );

    b64d_back #(
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .limit      (limit_reg),
        .q_ctl      (rd_ctl),
        .q_job      (head_job),
        .q_pop      (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .out_end    (m_tlast),
        .out_status (out_status),
        .out_len    (out_len)
    );

    assign m_tdata = {7'd0, out_len, out_status, out_byte};

endmodule
